### rtl/cra_pkg.sv
// ----------------------------------------------------------------------------
// cra_pkg
// Shared codes, widths and sequencer states of the core reservation admission
// controller.
// ----------------------------------------------------------------------------
package cra_pkg;

  // Field widths
  localparam int ID_W    = 32;
  localparam int TIME_W  = 32;
  localparam int LOAD_W  = 20;
  localparam int CAP_W   = 20;
  localparam int USED_W  = 24;
  localparam int MUL_W   = TIME_W + LOAD_W;
  localparam int NUM_W   = MUL_W + 1;

  // Request kinds
  localparam logic [1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_GET     = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_NO_SLOT   = 3'd3;
  localparam logic [2:0] ST_NO_CAP    = 3'd4;
  localparam logic [2:0] ST_FP_BUSY   = 3'd5;
  localparam logic [2:0] ST_STALE     = 3'd6;

  // Configuration register indexes
  localparam logic [7:0] CFG_CORE0_CAP = 8'd0;
  localparam logic [7:0] CFG_CORE1_CAP = 8'd1;

  // Sequencer states
  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_CHECK    = 10'b0000000010,
    S_MUL      = 10'b0000000100,
    S_DIV_GO   = 10'b0000001000,
    S_DIV_WAIT = 10'b0000010000,
    S_CMP_L    = 10'b0000100000,
    S_CMP_R    = 10'b0001000000,
    S_PLACE    = 10'b0010000000,
    S_LOOK_RD  = 10'b0100000000,
    S_LOOK_CMP = 10'b1000000000
  } state_t;

endpackage

### rtl/cra_div.sv
// ----------------------------------------------------------------------------
// cra_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cra_div #(
  parameter int NUM_W = 53,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DEN_W:0]   rem_sh;
  logic             q_bit;
  logic [DEN_W:0]   rem_sub;

  // trial subtract of the shifted remainder
  assign rem_sh  = {rem, quot[NUM_W-1]};
  assign q_bit   = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(NUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      quot  <= num;
    end else if (run) begin
      rem  <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], q_bit};
    end
  end

endmodule

### rtl/core_reservation_admission.sv
// ----------------------------------------------------------------------------
// core_reservation_admission
// Admission control of periodic jobs on two cores; a job goes to the core with the lower projected load ratio.
//
// Channel   | Handshake            | Payload
// request   | start / busy         | kind runtime period core_allow
//           |                      | request_flags ticket
// config    | cfg_valid / cfg_ready| cfg_index cfg_data
// result    | done (one cycle)     | status issued_id placed_core job_load
//           |                      | echo_* used_core0 used_core1 fp_core_mask
//
// Acquire runs check, multiply, the serial divider and two compare products
// before the placement state.
// Release and get walk the slot memory, one slot at a time, with a read state
// and a compare state per slot. Early failures finish from the check state.
// rst is synchronous; all slots are free and the next id is one afterwards.
// The receiver cannot stall: done marks the result for one cycle.
// ----------------------------------------------------------------------------
module core_reservation_admission #(
  parameter int SLOT_COUNT = 16,
  parameter int FULL_LOAD  = 1000000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] runtime,
  input  logic [31:0] period,
  input  logic [7:0]  core_allow,
  input  logic [7:0]  request_flags,
  input  logic [31:0] ticket,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] issued_id,
  output logic        placed_core,
  output logic [19:0] job_load,
  output logic [31:0] echo_runtime,
  output logic [31:0] echo_period,
  output logic [1:0]  echo_cores,
  output logic        echo_fp,
  output logic [23:0] used_core0,
  output logic [23:0] used_core1,
  output logic [1:0]  fp_core_mask
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  cra_pkg::state_t state;

  // latched request
  logic [1:0]                  kind_r;
  logic [cra_pkg::TIME_W-1:0]  rt_r;
  logic [cra_pkg::TIME_W-1:0]  pd_r;
  logic [7:0]                  allow_r;
  logic [7:0]                  flags_r;
  logic [cra_pkg::ID_W-1:0]    ticket_r;

  // configuration and job state
  logic [cra_pkg::CAP_W-1:0]   cap0;
  logic [cra_pkg::CAP_W-1:0]   cap1;
  logic [SLOT_COUNT-1:0]       live;
  logic [SLOT_COUNT-1:0]       on1;
  logic [SLOT_COUNT-1:0]       fpb;
  logic [cra_pkg::USED_W-1:0]  used0;
  logic [cra_pkg::USED_W-1:0]  used1;
  logic [CNT_W-1:0]            nonfp0;
  logic [CNT_W-1:0]            nonfp1;
  logic [cra_pkg::ID_W-1:0]    next_ticket;

  // work registers
  logic [IDX_W-1:0]            free_r;
  logic [IDX_W-1:0]            idx;
  logic [1:0]                  elig_r;
  logic [cra_pkg::LOAD_W-1:0]  load_r;
  logic [cra_pkg::MUL_W-1:0]   mul_q;
  logic [cra_pkg::MUL_W-1:0]   lhs_r;

  // slot memories
  logic [cra_pkg::ID_W-1:0]    mem_id      [SLOT_COUNT];
  logic [cra_pkg::LOAD_W-1:0]  mem_load    [SLOT_COUNT];
  logic [cra_pkg::TIME_W-1:0]  mem_runtime [SLOT_COUNT];
  logic [cra_pkg::TIME_W-1:0]  mem_period  [SLOT_COUNT];
  logic [1:0]                  mem_cores   [SLOT_COUNT];
  logic [cra_pkg::ID_W-1:0]    id_q;
  logic [cra_pkg::LOAD_W-1:0]  load_q;
  logic [cra_pkg::TIME_W-1:0]  runtime_q;
  logic [cra_pkg::TIME_W-1:0]  period_q;
  logic [1:0]                  cores_q;
  logic                        mem_we;

  // combinational helpers
  logic                        req_bad;
  logic                        fp_req;
  logic [1:0]                  fpm;
  logic [1:0]                  elig_cap;
  logic [1:0]                  elig_fp;
  logic [IDX_W-1:0]            free_idx;
  logic [cra_pkg::USED_W:0]    proj0;
  logic [cra_pkg::USED_W:0]    proj1;
  logic                        fit0;
  logic                        fit1;
  logic                        pick1;
  logic [31:0]                 mul_a;
  logic [cra_pkg::LOAD_W-1:0]  mul_b;
  logic [cra_pkg::MUL_W-1:0]   mul_p;
  logic                        div_start;
  logic                        div_done;
  logic [cra_pkg::NUM_W-1:0]   div_num;
  logic [cra_pkg::NUM_W-1:0]   div_quot;
  logic                        hit;

  assign busy         = (state != cra_pkg::S_IDLE);
  assign cfg_ready    = 1'b1;
  assign used_core0   = used0;
  assign used_core1   = used1;
  assign fp_core_mask = fpm;

  // request checks
  assign req_bad = (rt_r == '0) || (pd_r == '0) || (rt_r > pd_r) || (allow_r == '0) ||
                   (allow_r[7:2] != '0) || (flags_r[7:1] != '0);
  assign fp_req   = flags_r[0];
  assign fpm[0]   = |(live & fpb & ~on1);
  assign fpm[1]   = |(live & fpb & on1);
  assign elig_cap = allow_r[1:0] & {cap1 != '0, cap0 != '0};
  assign elig_fp  = fp_req ? (elig_cap & ~fpm) : elig_cap;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!live[i]) free_idx = IDX_W'(i);
    end
  end

  // projected use and fit per core
  assign proj0 = {1'b0, used0} + (cra_pkg::USED_W + 1)'(load_r);
  assign proj1 = {1'b0, used1} + (cra_pkg::USED_W + 1)'(load_r);
  assign fit0  = elig_r[0] && (proj0 <= (cra_pkg::USED_W + 1)'(cap0));
  assign fit1  = elig_r[1] && (proj1 <= (cra_pkg::USED_W + 1)'(cap1));

  // lhs_r = proj1*cap0, mul_q = proj0*cap1; core 1 wins a lower ratio or a non-fp tie with fewer non-fp jobs
  always_comb begin
    if (fit0 && fit1)
      pick1 = (lhs_r < mul_q) || ((lhs_r == mul_q) && !fp_req && (nonfp1 < nonfp0));
    else
      pick1 = fit1;
  end

  // shared multiplier
  always_comb begin
    unique case (state)
      cra_pkg::S_CMP_L: begin
        mul_a = 32'(proj1);
        mul_b = cap0;
      end
      cra_pkg::S_CMP_R: begin
        mul_a = 32'(proj0);
        mul_b = cap1;
      end
      default: begin
        mul_a = rt_r;
        mul_b = cra_pkg::LOAD_W'(FULL_LOAD);
      end
    endcase
  end
  assign mul_p = {{cra_pkg::LOAD_W{1'b0}}, mul_a} * {{32{1'b0}}, mul_b};

  // ceiling division of runtime*FULL_LOAD by period
  assign div_start = (state == cra_pkg::S_DIV_GO);
  assign div_num   = cra_pkg::NUM_W'(mul_q) + cra_pkg::NUM_W'(pd_r) - cra_pkg::NUM_W'(1);

  cra_div #(
    .NUM_W (cra_pkg::NUM_W),
    .DEN_W (cra_pkg::TIME_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (pd_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign hit    = live[idx] && (id_q == ticket_r);
  assign mem_we = (state == cra_pkg::S_PLACE) && (fit0 || fit1);

  // slot memories, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_id[free_r]      <= next_ticket;
      mem_load[free_r]    <= load_r;
      mem_runtime[free_r] <= rt_r;
      mem_period[free_r]  <= pd_r;
      mem_cores[free_r]   <= allow_r[1:0];
    end
    id_q      <= mem_id[idx];
    load_q    <= mem_load[idx];
    runtime_q <= mem_runtime[idx];
    period_q  <= mem_period[idx];
    cores_q   <= mem_cores[idx];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cap0 <= cra_pkg::CAP_W'(1000000);
      cap1 <= cra_pkg::CAP_W'(1000000);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cra_pkg::CFG_CORE0_CAP) cap0 <= cfg_data;
      if (cfg_index == cra_pkg::CFG_CORE1_CAP) cap1 <= cfg_data;
    end
  end

  // sequencer and job state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cra_pkg::S_IDLE;
      done        <= 1'b0;
      live        <= '0;
      on1         <= '0;
      fpb         <= '0;
      used0       <= '0;
      used1       <= '0;
      nonfp0      <= '0;
      nonfp1      <= '0;
      next_ticket <= cra_pkg::ID_W'(1);
      idx         <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        cra_pkg::S_IDLE: begin
          if (start) begin
            kind_r       <= kind;
            rt_r         <= runtime;
            pd_r         <= period;
            allow_r      <= core_allow;
            flags_r      <= request_flags;
            ticket_r     <= ticket;
            issued_id    <= '0;
            placed_core  <= 1'b0;
            job_load     <= '0;
            echo_runtime <= '0;
            echo_period  <= '0;
            echo_cores   <= '0;
            echo_fp      <= 1'b0;
            idx          <= '0;
            state        <= cra_pkg::S_CHECK;
          end
        end
        cra_pkg::S_CHECK: begin
          unique case (kind_r) inside
            cra_pkg::KIND_ACQUIRE: begin
              if (req_bad) begin
                status <= cra_pkg::ST_INVALID;
                done   <= 1'b1;
                state  <= cra_pkg::S_IDLE;
              end else if (next_ticket == '0) begin
                status <= cra_pkg::ST_EXHAUSTED;
                done   <= 1'b1;
                state  <= cra_pkg::S_IDLE;
              end else if (&live) begin
                status <= cra_pkg::ST_NO_SLOT;
                done   <= 1'b1;
                state  <= cra_pkg::S_IDLE;
              end else if (elig_cap == '0) begin
                status <= cra_pkg::ST_NO_CAP;
                done   <= 1'b1;
                state  <= cra_pkg::S_IDLE;
              end else if (elig_fp == '0) begin
                status <= cra_pkg::ST_FP_BUSY;
                done   <= 1'b1;
                state  <= cra_pkg::S_IDLE;
              end else begin
                elig_r <= elig_fp;
                free_r <= free_idx;
                state  <= cra_pkg::S_MUL;
              end
            end
            cra_pkg::KIND_RELEASE, cra_pkg::KIND_GET: begin
              if (ticket_r == '0) begin
                status <= cra_pkg::ST_STALE;
                done   <= 1'b1;
                state  <= cra_pkg::S_IDLE;
              end else begin
                state <= cra_pkg::S_LOOK_RD;
              end
            end
            default: begin
              status <= cra_pkg::ST_INVALID;
              done   <= 1'b1;
              state  <= cra_pkg::S_IDLE;
            end
          endcase
        end
        cra_pkg::S_MUL: begin
          mul_q <= mul_p;
          state <= cra_pkg::S_DIV_GO;
        end
        cra_pkg::S_DIV_GO: begin
          state <= cra_pkg::S_DIV_WAIT;
        end
        cra_pkg::S_DIV_WAIT: begin
          if (div_done) begin
            load_r <= div_quot[cra_pkg::LOAD_W-1:0];
            state  <= cra_pkg::S_CMP_L;
          end
        end
        cra_pkg::S_CMP_L: begin
          lhs_r <= mul_p;
          state <= cra_pkg::S_CMP_R;
        end
        cra_pkg::S_CMP_R: begin
          mul_q <= mul_p;
          state <= cra_pkg::S_PLACE;
        end
        cra_pkg::S_PLACE: begin
          done  <= 1'b1;
          state <= cra_pkg::S_IDLE;
          if (fit0 || fit1) begin
            status        <= cra_pkg::ST_OK;
            issued_id     <= next_ticket;
            placed_core   <= pick1;
            job_load      <= load_r;
            next_ticket   <= next_ticket + 1'b1;
            live[free_r]  <= 1'b1;
            on1[free_r]   <= pick1;
            fpb[free_r]   <= fp_req;
            if (pick1) begin
              used1 <= used1 + cra_pkg::USED_W'(load_r);
              if (!fp_req) nonfp1 <= nonfp1 + 1'b1;
            end else begin
              used0 <= used0 + cra_pkg::USED_W'(load_r);
              if (!fp_req) nonfp0 <= nonfp0 + 1'b1;
            end
          end else begin
            status <= cra_pkg::ST_NO_CAP;
          end
        end
        cra_pkg::S_LOOK_RD: begin
          state <= cra_pkg::S_LOOK_CMP;
        end
        cra_pkg::S_LOOK_CMP: begin
          if (hit) begin
            status <= cra_pkg::ST_OK;
            done   <= 1'b1;
            state  <= cra_pkg::S_IDLE;
            if (kind_r == cra_pkg::KIND_RELEASE) begin
              live[idx] <= 1'b0;
              on1[idx]  <= 1'b0;
              fpb[idx]  <= 1'b0;
              if (on1[idx]) begin
                used1 <= used1 - cra_pkg::USED_W'(load_q);
                if (!fpb[idx]) nonfp1 <= nonfp1 - 1'b1;
              end else begin
                used0 <= used0 - cra_pkg::USED_W'(load_q);
                if (!fpb[idx]) nonfp0 <= nonfp0 - 1'b1;
              end
            end else begin
              placed_core  <= on1[idx];
              job_load     <= load_q;
              echo_runtime <= runtime_q;
              echo_period  <= period_q;
              echo_cores   <= cores_q;
              echo_fp      <= fpb[idx];
            end
          end else if (idx == IDX_W'(SLOT_COUNT - 1)) begin
            status <= cra_pkg::ST_STALE;
            done   <= 1'b1;
            state  <= cra_pkg::S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= cra_pkg::S_LOOK_RD;
          end
        end
        default: begin
          state <= cra_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/cra_checker.sv
// ----------------------------------------------------------------------------
// cra_checker
// Port-level checks of the admission controller, bound to the top level.
// ----------------------------------------------------------------------------
module cra_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [31:0] issued_id
);

  // a result ends the transaction
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // an accepted request keeps the block busy next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not occupy the block");

  // one result per transaction
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // only a successful transaction carries an id
  a_id_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (status != cra_pkg::ST_OK)) |-> (issued_id == '0))
    else $error("id issued on a failing transaction");

  // status stays within its codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status <= cra_pkg::ST_STALE))
    else $error("status code out of range");

endmodule

bind core_reservation_admission cra_checker u_cra_checker (.*);
